// File: rtl/core/fbc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the frustum box cull block.
// No dependencies; compiled first.
package fbc_pkg;

  localparam int NUM_PLANES    = 6;
  localparam int COORD_WIDTH_D = 16;
  localparam int NORM_W        = 16;  // Q1.14 normal components and integer offset
  localparam int FRAC_BITS     = 14;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 6;   // six 64-bit registers at 8-byte spacing
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_IDX_LSB   = 3;
  localparam int VERDICT_W     = 2;

  localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_INSIDE   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_CROSSING = 2'd2;

  // Register layout: nx [15:0], ny [31:16], nz [47:32], d [63:48].
  typedef struct packed {
    logic signed [NORM_W-1:0] d;
    logic signed [NORM_W-1:0] nz;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nx;
  } plane_t;

  // Per-plane test outcome handed from a plane unit to the verdict stage.
  typedef struct packed {
    logic far_neg;   // box fully behind the plane
    logic near_neg;  // near corner behind the plane; box straddles it unless far_neg
  } plane_hit_t;

endpackage

// File: rtl/core/fbc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: box beats in, verdict beats out.
// Depends on fbc_pkg for the verdict width and the default coordinate width.
interface fbc_box_if #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_D
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] min_x;
  logic signed [COORD_WIDTH-1:0] min_y;
  logic signed [COORD_WIDTH-1:0] min_z;
  logic signed [COORD_WIDTH-1:0] max_x;
  logic signed [COORD_WIDTH-1:0] max_y;
  logic signed [COORD_WIDTH-1:0] max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface fbc_verdict_if;
  logic                             valid;
  logic                             ready;
  logic [fbc_pkg::VERDICT_W-1:0]    verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

// File: rtl/core/fbc_plane_eval.sv
`timescale 1ns / 1ps
// One plane of the cull test: corner select and multiply, then sum and sign.
// Depends on fbc_pkg. Two register stages, each with its own load enable.
module fbc_plane_eval #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_D
) (
  input  logic                           clk,
  input  logic                           en_mul,
  input  logic                           en_sum,
  input  fbc_pkg::plane_t                plane,
  input  logic signed [COORD_WIDTH-1:0]  lo [3],
  input  logic signed [COORD_WIDTH-1:0]  hi [3],
  output fbc_pkg::plane_hit_t            hit
);
  import fbc_pkg::*;

  localparam int PROD_W = NORM_W + COORD_WIDTH;
  localparam int OFS_W  = NORM_W + FRAC_BITS;
  localparam int DIST_W = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;

  logic signed [NORM_W-1:0]      nrm      [3];
  logic signed [COORD_WIDTH-1:0] far_c    [3];
  logic signed [COORD_WIDTH-1:0] near_c   [3];
  logic signed [PROD_W-1:0]      prod_far [3];
  logic signed [PROD_W-1:0]      prod_near[3];
  logic signed [DIST_W-1:0]      ofs;
  logic signed [DIST_W-1:0]      dist_far;
  logic signed [DIST_W-1:0]      dist_near;

  assign nrm[0] = plane.nx;
  assign nrm[1] = plane.ny;
  assign nrm[2] = plane.nz;

  // Far corner is the one furthest along the normal; zero counts as positive.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      far_c[a]  = nrm[a][NORM_W-1] ? lo[a] : hi[a];
      near_c[a] = nrm[a][NORM_W-1] ? hi[a] : lo[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      for (int a = 0; a < 3; a++) begin
        prod_far[a]  <= PROD_W'(nrm[a]) * PROD_W'(far_c[a]);
        prod_near[a] <= PROD_W'(nrm[a]) * PROD_W'(near_c[a]);
      end
    end
  end

  assign ofs = DIST_W'(plane.d) <<< FRAC_BITS;

  assign dist_far  = DIST_W'(prod_far[0]) + DIST_W'(prod_far[1])
                   + DIST_W'(prod_far[2]) + ofs;
  assign dist_near = DIST_W'(prod_near[0]) + DIST_W'(prod_near[1])
                   + DIST_W'(prod_near[2]) + ofs;

  always_ff @(posedge clk) begin
    if (en_sum) begin
      hit.far_neg  <= dist_far[DIST_W-1];
      hit.near_neg <= dist_near[DIST_W-1];
    end
  end

endmodule

// File: rtl/core/frustum_box_cull.sv
`timescale 1ns / 1ps
// Top level of the frustum box cull block: APB plane registers, pipeline control.
// Depends on fbc_pkg, fbc_if and fbc_plane_eval.
//
// Usage:
//   box_in carries one box per beat (min and max corner, signed integers).
//   verdict_out returns one beat per box, in order: 0 outside, 1 fully
//   inside, 2 crossing a plane.
//   The six planes are written over the APB port, 64 bits each at byte
//   address 8*i (left, right, bottom, top, near, far). Write them only while
//   no box is in flight. pready is always high; reads return the register.
//   Pipeline: input register, corner select and multiply, sum and sign,
//   verdict register. An accepted box passes through them in order and
//   its verdict leaves from the verdict register. Throughput is one box
//   per cycle while the receiver takes every verdict; all six planes are
//   evaluated in parallel, 36 multipliers in the multiply stage.
//   Each stage loads when it is empty or the stage after it moves, so a
//   stalled receiver fills the bubbles first and then holds every stage;
//   box_in.ready drops only when all four stages are full.
//   Reset clears all valid bits and sets every plane to zero, which makes
//   every box fully inside until planes are written.
module frustum_box_cull #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_D
) (
  input  logic                              clk,
  input  logic                              rst,
  fbc_box_if.sink                           box_in,
  fbc_verdict_if.source                     verdict_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fbc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [fbc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import fbc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] LAST_IDX = CFG_IDX_W'(NUM_PLANES - 1);

  // ---------------- configuration ----------------
  logic [CFG_DATA_W-1:0] plane_reg [NUM_PLANES];
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic                  cfg_wr;

  assign cfg_idx = paddr[CFG_IDX_LSB +: CFG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) plane_reg[i] <= '0;
    end else if (cfg_wr && cfg_idx <= LAST_IDX) begin
      plane_reg[cfg_idx] <= pwdata;
    end
  end

  assign prdata = (cfg_idx <= LAST_IDX) ? plane_reg[cfg_idx] : '0;

  // ---------------- pipeline control ----------------
  logic v_in, v_mul, v_sum, v_out;
  logic rdy_in, rdy_mul, rdy_sum, rdy_out;

  assign rdy_out = !v_out || verdict_out.ready;
  assign rdy_sum = !v_sum || rdy_out;
  assign rdy_mul = !v_mul || rdy_sum;
  assign rdy_in  = !v_in  || rdy_mul;

  assign box_in.ready = rdy_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in  <= 1'b0;
      v_mul <= 1'b0;
      v_sum <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (rdy_in)  v_in  <= box_in.valid;
      if (rdy_mul) v_mul <= v_in;
      if (rdy_sum) v_sum <= v_mul;
      if (rdy_out) v_out <= v_sum;
    end
  end

  // ---------------- input register ----------------
  logic signed [COORD_WIDTH-1:0] lo [3];
  logic signed [COORD_WIDTH-1:0] hi [3];

  always_ff @(posedge clk) begin
    if (rdy_in) begin
      lo[0] <= box_in.min_x;
      lo[1] <= box_in.min_y;
      lo[2] <= box_in.min_z;
      hi[0] <= box_in.max_x;
      hi[1] <= box_in.max_y;
      hi[2] <= box_in.max_z;
    end
  end

  // ---------------- plane units ----------------
  plane_hit_t hit [NUM_PLANES];

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fbc_plane_eval #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_eval (
      .clk    (clk),
      .en_mul (rdy_mul),
      .en_sum (rdy_sum),
      .plane  (plane_t'(plane_reg[p])),
      .lo     (lo),
      .hi     (hi),
      .hit    (hit[p])
    );
  end

  // ---------------- verdict ----------------
  logic                 any_out;
  logic                 any_cross;
  logic [VERDICT_W-1:0] verdict_next;
  logic [VERDICT_W-1:0] verdict;

  always_comb begin
    any_out   = 1'b0;
    any_cross = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      any_out   = any_out   | hit[p].far_neg;
      any_cross = any_cross | hit[p].near_neg;
    end
    if (any_out)        verdict_next = VERDICT_OUTSIDE;
    else if (any_cross) verdict_next = VERDICT_CROSSING;
    else                verdict_next = VERDICT_INSIDE;
  end

  always_ff @(posedge clk) begin
    if (rdy_out) verdict <= verdict_next;
  end

  assign verdict_out.valid   = v_out;
  assign verdict_out.verdict = verdict;

endmodule

// File: rtl/core/fbc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for frustum_box_cull, attached with a bind statement.
// Depends on fbc_pkg for verdict codes and the verdict width.
module fbc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [fbc_pkg::VERDICT_W-1:0]  verdict,
  input logic                           pready
);
  import fbc_pkg::*;

  // A stalled verdict beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("verdict beat changed while stalled");

  // Only the three defined verdict codes leave the block.
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == VERDICT_OUTSIDE || verdict == VERDICT_INSIDE ||
                   verdict == VERDICT_CROSSING))
    else $error("undefined verdict code");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("verdict valid right after reset");

  // With an empty output and no box taken in any cycle of the antecedent, nothing appears.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready) ##1 !(in_valid && in_ready) ##1
    !(in_valid && in_ready) ##1
    !(in_valid && in_ready) && !out_valid && !$past(out_valid) && !$past(out_valid, 2)
    |=> !out_valid)
    else $error("verdict beat without a box");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (box_in.valid),
  .in_ready  (box_in.ready),
  .out_valid (verdict_out.valid),
  .out_ready (verdict_out.ready),
  .verdict   (verdict_out.verdict),
  .pready    (pready)
);

// File: test/frustum_box_cull_test.sv
`timescale 1ns / 1ps
// Self-checking bench for frustum_box_cull: drives box beats with random stalls,
// programs the six planes over APB, predicts each verdict and checks it in order.
// Depends on fbc_pkg, fbc_if and the frustum_box_cull RTL.
module frustum_box_cull_test;
  import fbc_pkg::*;

  localparam int CW          = COORD_WIDTH_D;
  localparam int STALL_LIMIT = 2000;
  localparam int N_PHASES    = 12;
  localparam int PHASE_BOXES = 120;

  localparam logic signed [CW-1:0] C_MIN = 16'sh8000;
  localparam logic signed [CW-1:0] C_MAX = 16'sh7FFF;

  typedef enum logic [2:0] {
    REG_LEFT, REG_RIGHT, REG_BOTTOM, REG_TOP, REG_NEAR, REG_FAR, REG_UNUSED
  } plane_idx_t;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_mode_t;
  typedef enum logic {ROW_BOX, ROW_PLANE} row_kind_t;
  typedef enum int {PL_CUBE, PL_RANDOM, PL_EXTREME, PL_MIXED} plane_style_t;

  typedef struct packed {
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] min_z;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] max_y;
    logic signed [CW-1:0] max_z;
  } box_t;

  typedef struct packed {
    row_kind_t  kind;
    plane_idx_t reg_idx;
    logic [63:0] plane;
    box_t        box;
    logic        typed;     // verdict column holds the expected value
    logic [1:0]  verdict;
  } stim_row_t;

  // Axis-aligned cube |x|,|y|,|z| <= 100 in the first plane block.
  localparam stim_row_t DIRECTED [26] = '{
    '{ROW_BOX, REG_LEFT, 64'h0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      1'b1, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN},
      1'b1, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX},
      1'b1, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX},
      1'b1, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN},
      1'b1, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{16'sh5555, 16'sh5555, 16'sh5555,
      16'shAAAA, 16'shAAAA, 16'shAAAA}, 1'b1, VERDICT_INSIDE},
    '{ROW_PLANE, REG_LEFT,   64'h0064_0000_0000_4000, '0, 1'b0, VERDICT_INSIDE},
    '{ROW_PLANE, REG_RIGHT,  64'h0064_0000_0000_C000, '0, 1'b0, VERDICT_INSIDE},
    '{ROW_PLANE, REG_BOTTOM, 64'h0064_0000_4000_0000, '0, 1'b0, VERDICT_INSIDE},
    '{ROW_PLANE, REG_TOP,    64'h0064_0000_C000_0000, '0, 1'b0, VERDICT_INSIDE},
    '{ROW_PLANE, REG_NEAR,   64'h0064_4000_0000_0000, '0, 1'b0, VERDICT_INSIDE},
    '{ROW_PLANE, REG_FAR,    64'h0064_C000_0000_0000, '0, 1'b0, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{-16'sd10, -16'sd10, -16'sd10, 16'sd10, 16'sd10, 16'sd10},
      1'b1, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{16'sd200, 16'sd0, 16'sd0, 16'sd300, 16'sd0, 16'sd0},
      1'b1, VERDICT_OUTSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX},
      1'b1, VERDICT_CROSSING},
    '{ROW_BOX, REG_LEFT, 64'h0, '{16'sd50, -16'sd10, -16'sd10, 16'sd150, 16'sd10, 16'sd10},
      1'b0, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{16'sd10, 16'sd10, 16'sd10, -16'sd10, -16'sd10, -16'sd10},
      1'b0, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{-16'sd100, -16'sd100, -16'sd100,
      16'sd100, 16'sd100, 16'sd100}, 1'b0, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{-16'sd101, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      1'b0, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN},
      1'b0, VERDICT_INSIDE},
    '{ROW_PLANE, REG_LEFT,   64'h8000_8000_8000_8000, '0, 1'b0, VERDICT_INSIDE},
    '{ROW_PLANE, REG_RIGHT,  64'h7FFF_7FFF_7FFF_7FFF, '0, 1'b0, VERDICT_INSIDE},
    '{ROW_PLANE, REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN},
      1'b0, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX},
      1'b0, VERDICT_INSIDE},
    '{ROW_BOX, REG_LEFT, 64'h0, '{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX},
      1'b0, VERDICT_INSIDE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  fbc_box_if #(.COORD_WIDTH(CW)) box_ch ();
  fbc_verdict_if verdict_ch ();

  frustum_box_cull #(.COORD_WIDTH(CW)) dut (
    .clk         (clk),
    .rst         (rst),
    .box_in      (box_ch),
    .verdict_out (verdict_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  plane_t     plane_regs [NUM_PLANES];
  logic [1:0] expected_verdicts [$];
  logic       pin_valid = 1'b0;
  logic [1:0] pin_verdict = VERDICT_INSIDE;
  idle_mode_t src_mode = IDLE_NONE;
  idle_mode_t snk_mode = IDLE_NONE;
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  logic       beat_seen;
  logic [1:0] want;

  initial begin
    forever #5 clk = ~clk;
  end

  // Q.14 signed distance of an integer point from a plane; exact in 64 bits.
  function automatic longint plane_distance(plane_t pl, longint x, longint y, longint z);
    return longint'($signed(pl.nx)) * x + longint'($signed(pl.ny)) * y +
           longint'($signed(pl.nz)) * z + (longint'($signed(pl.d)) <<< FRAC_BITS);
  endfunction

  function automatic logic [1:0] cull_verdict(box_t b);
    plane_t pl;
    longint lo [3];
    longint hi [3];
    longint fc [3];
    longint nc [3];
    logic [2:0] neg;
    logic crossing;
    lo[0] = longint'(b.min_x);
    lo[1] = longint'(b.min_y);
    lo[2] = longint'(b.min_z);
    hi[0] = longint'(b.max_x);
    hi[1] = longint'(b.max_y);
    hi[2] = longint'(b.max_z);
    crossing = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      pl = plane_regs[p];
      neg = {pl.nz[NORM_W-1], pl.ny[NORM_W-1], pl.nx[NORM_W-1]};
      for (int a = 0; a < 3; a++) begin
        fc[a] = neg[a] ? lo[a] : hi[a];
        nc[a] = neg[a] ? hi[a] : lo[a];
      end
      if (plane_distance(pl, fc[0], fc[1], fc[2]) < 0) return VERDICT_OUTSIDE;
      if (plane_distance(pl, nc[0], nc[1], nc[2]) < 0) crossing = 1'b1;
    end
    return crossing ? VERDICT_CROSSING : VERDICT_INSIDE;
  endfunction

  function automatic int draw_gap(idle_mode_t mode);
    case (mode)
      IDLE_FULL:  return $urandom_range(0, 18);
      IDLE_LIGHT: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
      default:    return 0;
    endcase
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // Mostly boxes scattered around the cube of the given half size, the rest
  // raw 16-bit noise (inverted boxes included) and per-field extremes.
  function automatic box_t random_box(int half);
    box_t b;
    int lo_v [3];
    int hi_v [3];
    int span;
    int c;
    int e;
    int pick;
    pick = $urandom_range(0, 99);
    span = 3 * half + 200;
    for (int a = 0; a < 3; a++) begin
      if (pick < 65) begin
        c = int'($urandom_range(0, span)) - span / 2;
        e = ($urandom_range(0, 3) == 0) ? $urandom_range(0, half + 50)
                                        : $urandom_range(0, half / 8 + 10);
        lo_v[a] = clamp_coord(c - e);
        hi_v[a] = clamp_coord(c + e);
      end else if (pick < 88) begin
        lo_v[a] = int'($urandom_range(0, 65535)) - 32768;
        hi_v[a] = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        case ($urandom_range(0, 3))
          0: lo_v[a] = -32768;
          1: lo_v[a] = -1;
          2: lo_v[a] = 0;
          default: lo_v[a] = 32767;
        endcase
        case ($urandom_range(0, 3))
          0: hi_v[a] = -32768;
          1: hi_v[a] = -1;
          2: hi_v[a] = 0;
          default: hi_v[a] = 32767;
        endcase
      end
    end
    b.min_x = CW'(lo_v[0]);
    b.min_y = CW'(lo_v[1]);
    b.min_z = CW'(lo_v[2]);
    b.max_x = CW'(hi_v[0]);
    b.max_y = CW'(hi_v[1]);
    b.max_z = CW'(hi_v[2]);
    return b;
  endfunction

  function automatic logic [63:0] make_plane(plane_style_t style, int idx, int half);
    logic [NORM_W-1:0] comp [4];
    int jit;
    int axis;
    case (style)
      PL_RANDOM: return {$urandom, $urandom};
      PL_EXTREME: begin
        for (int k = 0; k < 4; k++) begin
          case ($urandom_range(0, 3))
            0: comp[k] = 16'h0000;
            1: comp[k] = 16'h7FFF;
            2: comp[k] = 16'h8000;
            default: comp[k] = 16'hFFFF;
          endcase
        end
      end
      default: begin
        if (style == PL_MIXED && $urandom_range(0, 2) == 0) return 64'h0;
        if (style == PL_MIXED && $urandom_range(0, 2) == 0) return {$urandom, $urandom};
        // inward-facing axis plane; even index faces +axis, odd faces -axis
        axis = idx / 2;
        jit = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2000);
        for (int k = 0; k < 3; k++) begin
          comp[k] = NORM_W'(int'($urandom_range(0, 2 * jit)) - jit);
          if (k == axis) comp[k] = comp[k] + ((idx % 2 == 1) ? 16'hC000 : 16'h4000);
        end
        comp[3] = NORM_W'(half + int'($urandom_range(0, 20)) - 10);
      end
    endcase
    return {comp[3], comp[2], comp[1], comp[0]};
  endfunction

  // Setup and access phase, then, for one of the six planes, a read back of the same register.
  task automatic write_plane(input plane_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CFG_ADDR_W'(int'(idx) << CFG_IDX_LSB);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    if (int'(idx) < NUM_PLANES) begin
      plane_regs[idx] = value;
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== value) begin
        $display("%0t: plane %0d read back expected %h actual %h", $time, idx, value, prdata);
        mismatch_count++;
      end
      @(negedge clk);
    end
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_box(input box_t b, input logic typed, input logic [1:0] verdict);
    int gap;
    gap = draw_gap(src_mode);
    @(negedge clk);
    if (gap > 0) begin
      box_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    box_ch.min_x = b.min_x;
    box_ch.min_y = b.min_y;
    box_ch.min_z = b.min_z;
    box_ch.max_x = b.max_x;
    box_ch.max_y = b.max_y;
    box_ch.max_z = b.max_z;
    pin_valid = typed;
    pin_verdict = verdict;
    box_ch.valid = 1'b1;
    do @(posedge clk); while (!box_ch.ready);
  endtask

  // Drop valid, let every verdict come back, then let the pipe settle.
  task automatic wait_idle();
    @(negedge clk);
    box_ch.valid = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    box_ch.valid = 1'b0;
    box_ch.min_x = '0;
    box_ch.min_y = '0;
    box_ch.min_z = '0;
    box_ch.max_x = '0;
    box_ch.max_y = '0;
    box_ch.max_z = '0;
    verdict_ch.ready = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) plane_regs[p] = '0;
  end

  // Verdict receiver: random back-pressure per beat.
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      gap = draw_gap(snk_mode);
      @(negedge clk);
      if (gap > 0) begin
        verdict_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      verdict_ch.ready = 1'b1;
      do @(posedge clk); while (!verdict_ch.valid);
    end
  end

  // Scoreboard and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      beat_seen = psel;
      if (box_ch.valid && box_ch.ready) begin
        beat_seen = 1'b1;
        expected_verdicts.push_back(pin_valid ? pin_verdict : cull_verdict({
          box_ch.min_x, box_ch.min_y, box_ch.min_z,
          box_ch.max_x, box_ch.max_y, box_ch.max_z}));
      end
      if (verdict_ch.valid && verdict_ch.ready) begin
        beat_seen = 1'b1;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: verdict beat with none expected, actual %0d",
                   $time, verdict_ch.verdict);
          mismatch_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict_ch.verdict !== want) begin
            $display("%0t: verdict expected %0d actual %0d", $time, want, verdict_ch.verdict);
            mismatch_count++;
          end
        end
      end
      idle_cycles = beat_seen ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d verdicts outstanding",
                 $time, idle_cycles, expected_verdicts.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int half;
    plane_style_t style;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_PLANE) begin
        wait_idle();
        write_plane(DIRECTED[i].reg_idx, DIRECTED[i].plane);
      end else begin
        send_box(DIRECTED[i].box, DIRECTED[i].typed, DIRECTED[i].verdict);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      half = (ph % 3 == 0) ? $urandom_range(1, 300) : $urandom_range(1, 30000);
      style = plane_style_t'(ph % 4);
      for (int i = 0; i < NUM_PLANES; i++)
        write_plane(plane_idx_t'(i), make_plane(style, i, half));
      src_mode = (ph == 0) ? IDLE_NONE : idle_mode_t'($urandom_range(0, 2));
      snk_mode = (ph == 0) ? IDLE_NONE : idle_mode_t'($urandom_range(0, 2));
      repeat (PHASE_BOXES) send_box(random_box(half), 1'b0, VERDICT_INSIDE);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/fbc_pkg.sv
rtl/core/fbc_if.sv
rtl/core/fbc_plane_eval.sv
rtl/core/frustum_box_cull.sv
rtl/core/fbc_checker.sv
test/frustum_box_cull_test.sv
